// ===== src/gb2d_pkg.sv =====
// ----------------------------------------------------------------------------
// gb2d_pkg
// Shared types and register codes for the 2D Gaussian blur core.
// ----------------------------------------------------------------------------
`default_nettype none

package gb2d_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_KSIZE  = 3'd0;
    localparam logic [2:0] CFG_WIDTH  = 3'd1;
    localparam logic [2:0] CFG_HEIGHT = 3'd2;
    localparam logic [2:0] CFG_COLOR  = 3'd3;
    localparam logic [2:0] CFG_TAPS0  = 3'd4;
    localparam logic [2:0] CFG_TAPS1  = 3'd5;
    localparam logic [2:0] CFG_TAPS2  = 3'd6;
    localparam logic [2:0] CFG_TAPS3  = 3'd7;

    // item kind codes
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    // controller to datapath
    typedef struct packed {
        logic accept;   // input item taken
        logic start;    // begin window walk
        logic step;     // issue one window tap
        logic load;     // move result into output register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic go;       // an output is owed and its window is complete
        logic last_tap; // walk is on the final tap
    } t_sts;

endpackage

`default_nettype wire

// ===== src/gb2d_ctrl.sv =====
// ----------------------------------------------------------------------------
// gb2d_ctrl
// Sequencer: accepts an item, walks the window, drains and hands off result.
// ----------------------------------------------------------------------------
`default_nettype none

module gb2d_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    input  wire gb2d_pkg::t_sts  i_sts,
    output gb2d_pkg::t_cmd       o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE, S_CHECK, S_RUN, S_DRAIN1, S_DRAIN2, S_LOAD
    } t_state;

    t_state r_state, n_state;
    logic   r_ovalid, n_ovalid;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    // next state and commands
    always_comb begin
        n_state  = r_state;
        n_ovalid = r_ovalid;
        o_cmd    = '0;
        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.go) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_RUN;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RUN: begin
                o_cmd.step = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = S_DRAIN1;
                end
            end
            S_DRAIN1: n_state = S_DRAIN2;
            S_DRAIN2: n_state = S_LOAD;
            S_LOAD: begin
                if (!r_ovalid || i_out_ready) begin
                    o_cmd.load = 1'b1;
                    n_ovalid   = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

endmodule

`default_nettype wire

// ===== src/gb2d_dp.sv =====
// ----------------------------------------------------------------------------
// gb2d_dp
// Datapath: config registers, position counters, line store, MAC pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module gb2d_dp #(
    parameter int MAX_KERNEL = 15,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int TAP_BITS   = 16
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire logic [2:0]      i_cfg_index,
    input  wire logic [63:0]     i_cfg_data,
    input  wire logic            i_kind,
    input  wire logic [7:0]      i_chan_0,
    input  wire logic [7:0]      i_chan_1,
    input  wire logic [7:0]      i_chan_2,
    input  wire gb2d_pkg::t_cmd  i_cmd,
    output gb2d_pkg::t_sts       o_sts,
    output logic [7:0]           o_out_0,
    output logic [7:0]           o_out_1,
    output logic [7:0]           o_out_2,
    output logic                 o_frame_last
);

    localparam int ROWS = MAX_KERNEL + 1;
    localparam int SW   = $clog2(ROWS);
    localparam int XAW  = $clog2(MAX_WIDTH);
    localparam int CWW  = $clog2(MAX_WIDTH + 1);
    localparam int RWW  = $clog2(MAX_HEIGHT + 1);
    localparam int KW   = $clog2(MAX_KERNEL + 1);
    localparam int SH   = 2 * TAP_BITS;
    localparam int PW   = SH + 8;
    localparam int AW   = SH + 18;
    localparam int DEPTH = ROWS * (2 ** XAW);

    // configuration
    logic [3:0]   r_ksize;
    logic [10:0]  r_width, r_height;
    logic         r_color;
    logic [255:0] r_taps;

    // stream position
    logic [RWW-1:0] r_in_row, r_out_row;
    logic [CWW-1:0] r_in_col, r_out_col;
    logic [SW-1:0]  r_in_slot, r_out_slot;

    // window walk
    logic [KW-1:0]          r_i, r_j;
    logic signed [RWW+1:0]  r_y;
    logic signed [CWW+1:0]  r_x, r_x0;
    logic [SW-1:0]          r_yslot;

    // pipeline
    logic [23:0]         mem [0:DEPTH-1];
    logic [23:0]         r_rd;
    logic [SH-1:0]       r_wgt;
    logic                r_v1, r_v2;
    logic [PW-1:0]       r_p0, r_p1, r_p2;
    logic [AW-1:0]       r_acc0, r_acc1, r_acc2;

    // effective geometry
    logic [KW-1:0]  k_eff, k_off;
    logic [CWW-1:0] w_eff;
    logic [RWW-1:0] h_eff;
    logic           in_open, in_row_end, out_last;
    logic           y_ok, x_ok;
    logic [SW+KW:0] slot_sum;

    always_comb begin
        int kk, ww, hh, lo, rr, cc;
        kk = int'(r_ksize);
        if (kk < 3) kk = 3;
        if (kk > MAX_KERNEL) kk = MAX_KERNEL;
        ww = int'(r_width);
        if (ww < 1) ww = 1;
        if (ww > MAX_WIDTH) ww = MAX_WIDTH;
        hh = int'(r_height);
        if (hh < 1) hh = 1;
        if (hh > MAX_HEIGHT) hh = MAX_HEIGHT;
        k_eff = KW'(kk);
        k_off = KW'((kk - 1) >> 1);
        w_eff = CWW'(ww);
        h_eff = RWW'(hh);
        lo = kk - 1 - ((kk - 1) >> 1);
        rr = int'(r_out_row) + lo;
        if (rr > hh - 1) rr = hh - 1;
        cc = int'(r_out_col) + lo;
        if (cc > ww - 1) cc = ww - 1;
        in_open    = int'(r_in_row) < hh;
        in_row_end = int'(r_in_col) + 1 >= ww;
        out_last   = (int'(r_out_row) == hh - 1) && (int'(r_out_col) == ww - 1);
        o_sts.go   = (int'(r_out_row) < hh) &&
                     ((rr < int'(r_in_row)) || (rr == int'(r_in_row) && cc < int'(r_in_col)));
        o_sts.last_tap = (r_i == k_eff - KW'(1)) && (r_j == k_eff - KW'(1));
    end

    assign y_ok = (r_y >= 0) && (r_y < $signed({2'b00, h_eff}));
    assign x_ok = (r_x >= 0) && (r_x < $signed({2'b00, w_eff}));
    assign slot_sum = (SW+KW+1)'(r_out_slot) + (SW+KW+1)'(ROWS) - (SW+KW+1)'(k_off);

    // tap lookup, lanes past fifteen read as zero
    function automatic logic [TAP_BITS-1:0] tap_of(input logic [255:0] taps,
                                                   input logic [KW-1:0] idx);
        logic [15:0]         lane;
        logic [TAP_BITS-1:0] t;
        int                  n;
        n    = int'(idx);
        lane = taps[16*(n & 15) +: 16];
        t    = '0;
        for (int b = 0; b < TAP_BITS; b++) begin
            if (b < 16) t[b] = lane[b];
        end
        return (n < 16) ? t : '0;
    endfunction

    // config registers and position counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksize    <= 4'd3;
            r_width    <= 11'd1024;
            r_height   <= 11'd1024;
            r_color    <= 1'b0;
            r_taps     <= '0;
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                gb2d_pkg::CFG_KSIZE:  r_ksize  <= i_cfg_data[3:0];
                gb2d_pkg::CFG_WIDTH:  r_width  <= i_cfg_data[10:0];
                gb2d_pkg::CFG_HEIGHT: r_height <= i_cfg_data[10:0];
                gb2d_pkg::CFG_COLOR:  r_color  <= i_cfg_data[0];
                gb2d_pkg::CFG_TAPS0:  r_taps[63:0]    <= i_cfg_data;
                gb2d_pkg::CFG_TAPS1:  r_taps[127:64]  <= i_cfg_data;
                gb2d_pkg::CFG_TAPS2:  r_taps[191:128] <= i_cfg_data;
                gb2d_pkg::CFG_TAPS3:  r_taps[255:192] <= i_cfg_data;
                default: ;
            endcase
            if (i_cfg_index inside {gb2d_pkg::CFG_KSIZE, gb2d_pkg::CFG_WIDTH,
                                    gb2d_pkg::CFG_HEIGHT, gb2d_pkg::CFG_COLOR}) begin
                r_in_row   <= '0;
                r_in_col   <= '0;
                r_in_slot  <= '0;
                r_out_row  <= '0;
                r_out_col  <= '0;
                r_out_slot <= '0;
            end
        end else if (i_cmd.load && out_last) begin
            // frame complete
            r_in_row   <= '0;
            r_in_col   <= '0;
            r_in_slot  <= '0;
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_slot <= '0;
        end else begin
            if (i_cmd.accept && i_kind == gb2d_pkg::KIND_PIXEL && in_open) begin
                if (in_row_end) begin
                    r_in_col  <= '0;
                    r_in_row  <= r_in_row + RWW'(1);
                    r_in_slot <= (int'(r_in_slot) == ROWS - 1) ? '0 : r_in_slot + SW'(1);
                end else begin
                    r_in_col <= r_in_col + CWW'(1);
                end
            end
            if (i_cmd.load) begin
                if (r_out_col == w_eff - CWW'(1)) begin
                    r_out_col  <= '0;
                    r_out_row  <= r_out_row + RWW'(1);
                    r_out_slot <= (int'(r_out_slot) == ROWS - 1) ? '0 : r_out_slot + SW'(1);
                end else begin
                    r_out_col <= r_out_col + CWW'(1);
                end
            end
        end
    end

    // line store
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && i_kind == gb2d_pkg::KIND_PIXEL && in_open) begin
            mem[{r_in_slot, r_in_col[XAW-1:0]}] <= {i_chan_2, i_chan_1, i_chan_0};
        end
        r_rd <= mem[{r_yslot, r_x[XAW-1:0]}];
    end

    // window walk
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_i  <= '0;
            r_j  <= '0;
            r_y  <= $signed({2'b00, r_out_row}) - $signed((RWW+2)'(k_off));
            r_x  <= $signed({2'b00, r_out_col}) - $signed((CWW+2)'(k_off));
            r_x0 <= $signed({2'b00, r_out_col}) - $signed((CWW+2)'(k_off));
            r_yslot <= (slot_sum >= (SW+KW+1)'(ROWS)) ? SW'(slot_sum - (SW+KW+1)'(ROWS))
                                                      : SW'(slot_sum);
        end else if (i_cmd.step) begin
            if (r_j == k_eff - KW'(1)) begin
                r_j     <= '0;
                r_x     <= r_x0;
                r_i     <= r_i + KW'(1);
                r_y     <= r_y + (RWW+2)'(1);
                r_yslot <= (int'(r_yslot) == ROWS - 1) ? '0 : r_yslot + SW'(1);
            end else begin
                r_j <= r_j + KW'(1);
                r_x <= r_x + (CWW+2)'(1);
            end
        end
    end

    // weight, product and accumulate stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.step && y_ok && x_ok;
            r_v2 <= r_v1;
        end
        r_wgt <= SH'(tap_of(r_taps, r_i)) * SH'(tap_of(r_taps, r_j));
        if (r_v1) begin
            r_p0 <= PW'(r_wgt) * PW'(r_rd[7:0]);
            r_p1 <= PW'(r_wgt) * PW'(r_rd[15:8]);
            r_p2 <= PW'(r_wgt) * PW'(r_rd[23:16]);
        end
        if (i_cmd.start) begin
            r_acc0 <= '0;
            r_acc1 <= '0;
            r_acc2 <= '0;
        end else if (r_v2) begin
            r_acc0 <= r_acc0 + AW'(r_p0);
            r_acc1 <= r_acc1 + AW'(r_p1);
            r_acc2 <= r_acc2 + AW'(r_p2);
        end
    end

    // scale, saturate and register result
    function automatic logic [7:0] sat8(input logic [AW-1:0] a);
        return (|a[AW-1:SH+8]) ? 8'hFF : a[SH+7:SH];
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            o_out_0      <= sat8(r_acc0);
            o_out_1      <= r_color ? sat8(r_acc1) : 8'd0;
            o_out_2      <= r_color ? sat8(r_acc2) : 8'd0;
            o_frame_last <= out_last;
        end
    end

endmodule

`default_nettype wire

// ===== src/gaussian_blur_2d_core.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_2d_core
// Separable Gaussian blur over a raster pixel stream with a ring line store.
//
//  channel | handshake                | payload
//  --------+--------------------------+-----------------------------------
//  input   | i_in_valid / o_in_ready  | i_kind, i_chan_0..2
//  output  | o_out_valid / i_out_ready| o_out_0..2, o_frame_last
//  config  | i_cfg_we                 | i_cfg_index, i_cfg_data
//
// An item that yields no result is accepted, checked and released; one that yields
// a result also walks its k*k window, with the single-read line store port feeding one
// window tap per cycle into the multiply-accumulate pipeline, then drains and loads.
// A finished result waits in the output register while the next item is taken;
// loading the next result stalls until that register has been taken.
// Synchronous active-low reset; no clearing pass over the line store.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_2d_core #(
    parameter int MAX_KERNEL = 15,
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int TAP_BITS   = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [63:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_kind,
    input  wire logic [7:0]  i_chan_0,
    input  wire logic [7:0]  i_chan_1,
    input  wire logic [7:0]  i_chan_2,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [7:0]       o_out_0,
    output logic [7:0]       o_out_1,
    output logic [7:0]       o_out_2,
    output logic             o_frame_last
);

    gb2d_pkg::t_cmd cmd;
    gb2d_pkg::t_sts sts;

    gb2d_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    gb2d_dp #(
        .MAX_KERNEL (MAX_KERNEL),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .TAP_BITS   (TAP_BITS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_kind       (i_kind),
        .i_chan_0     (i_chan_0),
        .i_chan_1     (i_chan_1),
        .i_chan_2     (i_chan_2),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .o_out_0      (o_out_0),
        .o_out_1      (o_out_1),
        .o_out_2      (o_out_2),
        .o_frame_last (o_frame_last)
    );

endmodule

`default_nettype wire

// ===== sim/gaussian_blur_2d_core_tb.sv =====
// ----------------------------------------------------------------------------
// gaussian_blur_2d_core_tb
// Self-checking bench for the 2D Gaussian blur core. Frames of random size,
// kernel, color mode and taps are streamed through the input port with random
// gaps and output stalls. A line-store model in the scoreboard predicts each
// blurred pixel, and every accepted result is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module gaussian_blur_2d_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_K        = 15;
    localparam int MAX_W        = 1024;
    localparam int MAX_H        = 1024;
    localparam int RING_ROWS    = MAX_K + 1;
    localparam int ITEM_TARGET  = 950;
    localparam int SETTLE_CYC   = 300;   // longest item walks the largest k*k window
    localparam int HOLD_CYC     = 600;
    localparam int STALL_LIMIT  = 5000;

    typedef struct packed {
        bit [7:0] ch0;
        bit [7:0] ch1;
        bit [7:0] ch2;
        bit       last;
    } t_blur_px;

    // Scoreboard: line-store model of the blur plus the queue of owed pixels
    class blur_scoreboard;
        bit [23:0]   ring [RING_ROWS*MAX_W];
        bit [3:0]    ksize;
        bit [10:0]   width;
        bit [10:0]   height;
        bit          color;
        bit [63:0]   taps [4];
        int unsigned in_row, in_col, sent;
        t_blur_px    owed [$];
        int unsigned n_bad, n_checked, n_items;

        function void restart();
            in_row = 0;
            in_col = 0;
            sent   = 0;
        endfunction

        function void clear();
            foreach (ring[i]) ring[i] = '0;
            ksize  = 4'd3;
            width  = 11'd1024;
            height = 11'd1024;
            color  = 1'b0;
            foreach (taps[i]) taps[i] = '0;
            restart();
        endfunction

        function void write_reg(bit [2:0] idx, bit [63:0] v);
            case (idx)
                gb2d_pkg::CFG_KSIZE:  ksize  = v[3:0];
                gb2d_pkg::CFG_WIDTH:  width  = v[10:0];
                gb2d_pkg::CFG_HEIGHT: height = v[10:0];
                gb2d_pkg::CFG_COLOR:  color  = v[0];
                default: begin
                    taps[idx - gb2d_pkg::CFG_TAPS0] = v;
                    return;
                end
            endcase
            restart();
        endfunction

        function int unsigned eff_k();
            return (ksize < 3) ? 3 : ((ksize > MAX_K) ? MAX_K : ksize);
        endfunction
        function int unsigned eff_w();
            return (width < 1) ? 1 : ((width > MAX_W) ? MAX_W : width);
        endfunction
        function int unsigned eff_h();
            return (height < 1) ? 1 : ((height > MAX_H) ? MAX_H : height);
        endfunction

        // frame still in progress: pixels or outputs owed
        function bit frame_open();
            return (sent != 0) || (in_row != 0) || (in_col != 0);
        endfunction

        function bit [7:0] sat(longint unsigned s);
            s = s >> 32;
            return (s > 255) ? 8'd255 : s[7:0];
        endfunction

        function void note_input(bit kind, bit [7:0] c0, bit [7:0] c1, bit [7:0] c2);
            int unsigned     k, w, h, off, lo, q, r, c, rr, cc;
            int              y, x;
            longint unsigned tp [MAX_K];
            longint unsigned wgt, s0, s1, s2;
            bit [23:0]       p;
            t_blur_px        e;
            k = eff_k();
            w = eff_w();
            h = eff_h();
            off = (k - 1) / 2;
            lo = k - 1 - off;
            n_items++;
            if (kind == gb2d_pkg::KIND_PIXEL && in_row < h && in_col < w) begin
                ring[(in_row % RING_ROWS) * MAX_W + in_col] = {c2, c1, c0};
                in_col++;
                if (in_col >= w) begin
                    in_col = 0;
                    in_row++;
                end
            end
            if (sent >= w * h) return;
            q = sent;
            r = q / w;
            c = q % w;
            rr = (r + lo < h) ? r + lo : h - 1;
            cc = (c + lo < w) ? c + lo : w - 1;
            if (rr * w + cc >= in_row * w + in_col) return;
            for (int i = 0; i < k; i++) tp[i] = 64'(taps[i / 4][16 * (i % 4) +: 16]);
            s0 = 0;
            s1 = 0;
            s2 = 0;
            for (int i = 0; i < k; i++) begin
                y = int'(r) - int'(off) + i;
                if (y < 0 || y >= int'(h)) continue;
                for (int j = 0; j < k; j++) begin
                    x = int'(c) - int'(off) + j;
                    if (x < 0 || x >= int'(w)) continue;
                    p = ring[(y % RING_ROWS) * MAX_W + x];
                    wgt = tp[i] * tp[j];
                    s0 += wgt * p[7:0];
                    s1 += wgt * p[15:8];
                    s2 += wgt * p[23:16];
                end
            end
            e.ch0  = sat(s0);
            e.ch1  = color ? sat(s1) : 8'd0;
            e.ch2  = color ? sat(s2) : 8'd0;
            e.last = (q + 1 == w * h);
            owed.push_back(e);
            sent++;
            if (sent >= w * h) restart();
        endfunction

        function void check_result(t_blur_px got);
            t_blur_px e;
            n_checked++;
            if (owed.size() == 0) begin
                n_bad++;
                if (n_bad <= 10) $display("result with nothing owed: %0h %0h %0h last=%0b",
                    got.ch0, got.ch1, got.ch2, got.last);
                return;
            end
            e = owed.pop_front();
            if (e != got) begin
                n_bad++;
                if (n_bad <= 10)
                    $display("result %0d: exp %0h %0h %0h last=%0b, got %0h %0h %0h last=%0b",
                        n_checked, e.ch0, e.ch1, e.ch2, e.last,
                        got.ch0, got.ch1, got.ch2, got.last);
            end
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_kind;
    logic [7:0]  i_chan_0, i_chan_1, i_chan_2;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_0, o_out_1, o_out_2;
    logic        o_frame_last;

    blur_scoreboard sb;
    bit          calm;        // no idling on either side
    bit          hold_go;     // ask the receiver for a long hold-off
    int unsigned stall_cnt;
    int unsigned n_frames;

    gaussian_blur_2d_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_chan_0     (i_chan_0),
        .i_chan_1     (i_chan_1),
        .i_chan_2     (i_chan_2),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_out_0      (o_out_0),
        .o_out_1      (o_out_1),
        .o_out_2      (o_out_2),
        .o_frame_last (o_frame_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Output side: random stalls, one long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                i_out_ready <= 1'b0;
            end else if (hold_go) begin
                hold_go = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYC) @(posedge i_clk);
            end else begin
                i_out_ready <= calm || ($urandom_range(99) >= 34);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready)
            sb.check_result('{o_out_0, o_out_1, o_out_2, o_frame_last});
    end

    // Watchdog: cycles with no item moving on any channel
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready) ||
            i_cfg_we)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt == STALL_LIMIT) begin
            $display("timeout after %0d stalled cycles", stall_cnt);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Offer one item, with a random gap first, and hold it until taken
    task automatic send_item(bit kind, bit [7:0] c0, bit [7:0] c1, bit [7:0] c2);
        while (!calm && $urandom_range(99) < 34) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_kind     <= kind;
        i_chan_0   <= c0;
        i_chan_1   <= c1;
        i_chan_2   <= c2;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        sb.note_input(kind, c0, c1, c2);
    endtask

    task automatic send_pixel();
        send_item(gb2d_pkg::KIND_PIXEL, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(255)));
    endtask

    // Wait for every owed pixel and for the block to settle, then write
    task automatic write_reg(bit [2:0] idx, bit [63:0] v);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, v);
    endtask

    // Taps: near-unity Gaussian-like spread, or fully random to saturate
    task automatic write_taps(int unsigned k, bit wild);
        bit [63:0] v;
        for (int m = 0; m < 4; m++) begin
            v = {$urandom, $urandom};
            if (!wild)
                for (int n = 0; n < 4; n++) v[16*n +: 16] = 16'($urandom_range(131072 / k));
            write_reg(3'(int'(gb2d_pkg::CFG_TAPS0) + m), v);
        end
    endtask

    task automatic setup(bit [3:0] k, bit [10:0] w, bit [10:0] h, bit col, bit wild);
        write_reg(gb2d_pkg::CFG_KSIZE, 64'(k));
        write_reg(gb2d_pkg::CFG_WIDTH, 64'(w));
        write_reg(gb2d_pkg::CFG_HEIGHT, 64'(h));
        write_reg(gb2d_pkg::CFG_COLOR, 64'(col));
        write_taps(sb.eff_k(), wild);
    endtask

    // Drain a frame; some drain items are pixels, which the block drops
    task automatic drain();
        while (sb.frame_open()) begin
            if ($urandom_range(99) < 20) send_pixel();
            else send_item(gb2d_pkg::KIND_FLUSH, 8'($urandom_range(255)),
                           8'($urandom_range(255)), 8'($urandom_range(255)));
        end
        n_frames++;
    endtask

    initial begin
        bit [3:0]    k;
        bit [10:0]   w, h;
        int unsigned npx;

        sb = new();
        sb.clear();
        calm        = 1'b0;
        hold_go     = 1'b0;
        stall_cnt   = 0;
        n_frames    = 0;
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = gb2d_pkg::CFG_KSIZE;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_kind      = gb2d_pkg::KIND_PIXEL;
        i_chan_0    = '0;
        i_chan_1    = '0;
        i_chan_2    = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // flushes with nothing owed after reset
        repeat (3) send_item(gb2d_pkg::KIND_FLUSH, 8'hff, 8'h00, 8'hff);

        // largest kernel, fully random taps: saturation with extreme pixels
        setup(4'd15, 11'd4, 11'd3, 1'b1, 1'b0);
        write_taps(15, 1'b1);
        for (int i = 0; i < 12; i++)
            if (i % 2) send_item(gb2d_pkg::KIND_PIXEL, 8'hff, 8'hff, 8'hff);
            else send_item(gb2d_pkg::KIND_PIXEL, 8'h00, 8'h00, 8'h00);
        drain();

        // kernel and size below range, gray mode
        setup(4'd0, 11'd0, 11'd0, 1'b0, 1'b0);
        send_item(gb2d_pkg::KIND_PIXEL, 8'h80, 8'h7f, 8'h01);
        drain();

        // widest frame, abandoned mid-row by a geometry write
        setup(4'd2, 11'h7ff, 11'h7ff, 1'b1, 1'b0);
        repeat (6) send_pixel();

        // even kernel
        setup(4'd4, 11'd5, 11'd2, 1'b1, 1'b0);
        repeat (10) send_pixel();
        drain();

        // random frames
        while (sb.n_items < ITEM_TARGET) begin
            k = ($urandom_range(99) < 70) ? 4'($urandom_range(7)) : 4'($urandom_range(15));
            w = ($urandom_range(19) == 0) ? 11'd0 : 11'($urandom_range(1, 12));
            h = ($urandom_range(19) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
            setup(k, w, h, 1'($urandom_range(1)), $urandom_range(99) < 20);
            calm = (sb.n_items > 400 && sb.n_items < 520);
            if (n_frames == 8) hold_go = 1'b1;
            npx = sb.eff_w() * sb.eff_h();
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(npx)) send_pixel();
            end else begin
                repeat (npx) send_pixel();
                drain();
            end
        end
        calm = 1'b0;
        i_in_valid <= 1'b0;

        while (sb.owed.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("covered %0d items over %0d frames, %0d blurred pixels checked",
            sb.n_items, n_frames, sb.n_checked);
        $display("kernels 3..15 incl. even and out-of-range, gray and color, saturating taps");
        if (sb.n_bad == 0) begin
            $display("end of test: clean");
        end else begin
            $display("%0d mismatches", sb.n_bad);
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
src/gb2d_pkg.sv
src/gb2d_ctrl.sv
src/gb2d_dp.sv
src/gaussian_blur_2d_core.sv
sim/gaussian_blur_2d_core_tb.sv
